// ----- sv/sexpr_token_scanner_top_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the S-expression token scanner
// Shared concurrent assertion forms, reset-qualified on arst_n.
// ----------------------------------------------------------------------------
`ifndef SEXPR_TOKEN_SCANNER_TOP_MACROS_SVH
`define SEXPR_TOKEN_SCANNER_TOP_MACROS_SVH

// same-cycle implication
`define STS_ASSERT_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define STS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- sv/sts_pkg.sv -----
// ----------------------------------------------------------------------------
// S-expression token scanner package
// Token kinds, error codes, scan modes, result bundle and byte classes.
// ----------------------------------------------------------------------------
package sts_pkg;

	localparam int SPAN_BITS = 16;
	localparam int MAX_RESULTS = 3;

	typedef enum logic [2:0] {
		KIND_LPAREN = 3'd0,
		KIND_RPAREN = 3'd1,
		KIND_STRING = 3'd2,
		KIND_IDENT  = 3'd3,
		KIND_INT    = 3'd4,
		KIND_END    = 3'd5,
		KIND_ERROR  = 3'd6
	} token_kind_t;

	typedef enum logic [2:0] {
		ERR_NONE       = 3'd0,
		ERR_STR_BYTE   = 3'd1,
		ERR_IDENT_BYTE = 3'd2,
		ERR_INT_BYTE   = 3'd3,
		ERR_UNTERM     = 3'd4
	} err_code_t;

	typedef enum logic [2:0] {
		MODE_IDLE  = 3'd0,
		MODE_STR   = 3'd1,
		MODE_IDENT = 3'd2,
		MODE_INT   = 3'd3,
		MODE_HALT  = 3'd4
	} scan_mode_t;

	typedef struct packed {
		token_kind_t           kind;
		err_code_t             err;
		logic [SPAN_BITS-1:0]  span_s;
		logic [SPAN_BITS-1:0]  span_e;
	} result_t;

	typedef struct packed {
		logic [1:0]                cnt;
		result_t [MAX_RESULTS-1:0] slot;
	} bundle_t;

	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_PRINT_LO = 8'h20;
	localparam logic [7:0] CH_PRINT_HI = 8'h7E;

	function automatic logic is_letter(input logic [7:0] c);
		return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c >= 8'h30 && c <= 8'h39;
	endfunction

	// tab, LF, CR, space and both parentheses
	function automatic logic is_term(input logic [7:0] c);
		return c == 8'h09 || c == 8'h0A || c == 8'h0D || c == 8'h20 ||
			c == CH_LPAREN || c == CH_RPAREN;
	endfunction

endpackage

// ----- sv/sts_core.sv -----
// ----------------------------------------------------------------------------
// Scanner core
// Scan mode, position and token start; decodes one byte into a result bundle.
// ----------------------------------------------------------------------------
module sts_core import sts_pkg::*; #(
	parameter int POS_BITS = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [7:0] data_byte,
	input  logic       end_of_buffer,
	input  logic       consume,
	output bundle_t    bundle
);

	scan_mode_t            mode_q, mode_n;
	logic [POS_BITS-1:0]   pos_q, pos_n, tb_q, tb_n, nxt;
	logic                  idle_pass, halted;
	logic [1:0]            cnt;
	result_t [MAX_RESULTS-1:0] slot;

	assign nxt = pos_q + POS_BITS'(1);

	always_comb begin
		mode_n    = mode_q;
		tb_n      = tb_q;
		pos_n     = pos_q;
		idle_pass = 1'b0;
		halted    = 1'b0;
		cnt       = 2'd0;
		slot      = '0;
		case (mode_q)
			MODE_IDLE: begin
				idle_pass = 1'b1;
			end
			MODE_STR: begin
				if (data_byte == CH_QUOTE) begin
					slot[cnt] = '{KIND_STRING, ERR_NONE, SPAN_BITS'(tb_q), SPAN_BITS'(pos_q)};
					cnt = cnt + 2'd1;
					mode_n = MODE_IDLE;
				end else if (data_byte < CH_PRINT_LO || data_byte > CH_PRINT_HI) begin
					slot[cnt] = '{KIND_ERROR, ERR_STR_BYTE, SPAN_BITS'(tb_q), SPAN_BITS'(pos_q)};
					cnt = cnt + 2'd1;
					mode_n = MODE_HALT;
				end
			end
			MODE_IDENT, MODE_INT: begin
				if (is_term(data_byte)) begin
					slot[cnt] = '{(mode_q == MODE_IDENT) ? KIND_IDENT : KIND_INT, ERR_NONE,
						SPAN_BITS'(tb_q), SPAN_BITS'(pos_q)};
					cnt = cnt + 2'd1;
					mode_n = MODE_IDLE;
					idle_pass = 1'b1;
				end else if ((mode_q == MODE_IDENT) ? !is_letter(data_byte)
						: !is_digit(data_byte)) begin
					slot[cnt] = '{KIND_ERROR,
						(mode_q == MODE_IDENT) ? ERR_IDENT_BYTE : ERR_INT_BYTE,
						SPAN_BITS'(tb_q), SPAN_BITS'(pos_q)};
					cnt = cnt + 2'd1;
					mode_n = MODE_HALT;
				end
			end
			default: begin
				mode_n = MODE_HALT;
				halted = 1'b1;
			end
		endcase

		if (!halted) begin
			if (idle_pass) begin
				if (data_byte == CH_LPAREN) begin
					slot[cnt] = '{KIND_LPAREN, ERR_NONE, SPAN_BITS'(pos_q), SPAN_BITS'(nxt)};
					cnt = cnt + 2'd1;
				end else if (data_byte == CH_RPAREN) begin
					slot[cnt] = '{KIND_RPAREN, ERR_NONE, SPAN_BITS'(pos_q), SPAN_BITS'(nxt)};
					cnt = cnt + 2'd1;
				end else if (data_byte == CH_QUOTE) begin
					mode_n = MODE_STR;
					tb_n = nxt;
				end else if (is_letter(data_byte)) begin
					mode_n = MODE_IDENT;
					tb_n = pos_q;
				end else if (is_digit(data_byte)) begin
					mode_n = MODE_INT;
					tb_n = pos_q;
				end
			end

			pos_n = nxt;

			if (end_of_buffer && mode_n != MODE_HALT) begin
				if (mode_n == MODE_STR) begin
					slot[cnt] = '{KIND_ERROR, ERR_UNTERM, SPAN_BITS'(tb_n), SPAN_BITS'(nxt)};
					cnt = cnt + 2'd1;
					mode_n = MODE_HALT;
				end else begin
					if (mode_n == MODE_IDENT || mode_n == MODE_INT) begin
						slot[cnt] = '{(mode_n == MODE_IDENT) ? KIND_IDENT : KIND_INT,
							ERR_NONE, SPAN_BITS'(tb_n), SPAN_BITS'(nxt)};
						cnt = cnt + 2'd1;
					end
					slot[cnt] = '{KIND_END, ERR_NONE, SPAN_BITS'(nxt), SPAN_BITS'(nxt)};
					cnt = cnt + 2'd1;
					mode_n = MODE_IDLE;
					pos_n = '0;
					tb_n = '0;
				end
			end
		end

		bundle.cnt  = cnt;
		bundle.slot = slot;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
			pos_q  <= '0;
			tb_q   <= '0;
		end else if (consume) begin
			mode_q <= mode_n;
			pos_q  <= pos_n;
			tb_q   <= tb_n;
		end
	end

endmodule

// ----- sv/sts_outbuf.sv -----
// ----------------------------------------------------------------------------
// Result buffer
// Holds one bundle of up to three results and sends them one per transaction.
// ----------------------------------------------------------------------------
module sts_outbuf import sts_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  bundle_t               bundle,
	output logic                  free,
	output logic                  token_valid,
	input  logic                  token_stall,
	output logic [2:0]            token_kind,
	output logic [2:0]            error_code,
	output logic [SPAN_BITS-1:0]  span_start,
	output logic [SPAN_BITS-1:0]  span_end,
	output logic                  last_of_run
);

	logic [1:0]                cnt_q, idx_q;
	result_t [MAX_RESULTS-1:0] slot_q;
	result_t                   cur;
	logic                      fire, done, load;

	assign cur         = slot_q[idx_q];
	assign token_valid = cnt_q != 2'd0;
	assign last_of_run = idx_q == (cnt_q - 2'd1);
	assign token_kind  = cur.kind;
	assign error_code  = cur.err;
	assign span_start  = cur.span_s;
	assign span_end    = cur.span_e;

	assign fire = token_valid && !token_stall;
	assign done = fire && last_of_run;
	assign free = !token_valid || done;
	assign load = push && bundle.cnt != 2'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
			idx_q <= 2'd0;
		end else if (load) begin
			cnt_q <= bundle.cnt;
			idx_q <= 2'd0;
		end else if (done) begin
			cnt_q <= 2'd0;
			idx_q <= 2'd0;
		end else if (fire) begin
			idx_q <= idx_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			slot_q <= bundle.slot;
		end
	end

endmodule

// ----- sv/sexpr_token_scanner_top.sv -----
// ----------------------------------------------------------------------------
// S-expression token scanner
// Path: a byte is held in the input register, and its results in the result buffer, before they are offered.
// Throughput: one byte per cycle while each byte yields at most one token and token_stall
//   is low; a byte yielding several tokens holds the output port while they are sent in turn.
// Reset: arst_n clears scan mode, position, token start and both buffers.
// ----------------------------------------------------------------------------
module sexpr_token_scanner_top import sts_pkg::*; #(
	parameter int POS_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  data_valid,
	output logic                  data_stall,
	input  logic [7:0]            data_byte,
	input  logic                  end_of_buffer,
	output logic                  token_valid,
	input  logic                  token_stall,
	output logic [2:0]            token_kind,
	output logic [2:0]            error_code,
	output logic [SPAN_BITS-1:0]  span_start,
	output logic [SPAN_BITS-1:0]  span_end,
	output logic                  last_of_run
);

	logic       valid_s1, eob_s1, go, free;
	logic [7:0] byte_s1;
	bundle_t    bundle;

	assign go         = valid_s1 && (bundle.cnt == 2'd0 || free);
	assign data_stall = valid_s1 && !go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!data_stall) begin
			valid_s1 <= data_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!data_stall && data_valid) begin
			byte_s1 <= data_byte;
			eob_s1  <= end_of_buffer;
		end
	end

	sts_core #(.POS_BITS(POS_BITS)) u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.data_byte     (byte_s1),
		.end_of_buffer (eob_s1),
		.consume       (go),
		.bundle        (bundle)
	);

	sts_outbuf u_outbuf (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (go),
		.bundle      (bundle),
		.free        (free),
		.token_valid (token_valid),
		.token_stall (token_stall),
		.token_kind  (token_kind),
		.error_code  (error_code),
		.span_start  (span_start),
		.span_end    (span_end),
		.last_of_run (last_of_run)
	);

endmodule

// ----- sv/sts_checker.sv -----
// ----------------------------------------------------------------------------
// Scanner port checker
// Port-level properties of the token stream, bound to the top level.
// ----------------------------------------------------------------------------
`include "sexpr_token_scanner_top_macros.svh"

module sts_checker import sts_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  token_valid,
	input logic                  token_stall,
	input logic [2:0]            token_kind,
	input logic [2:0]            error_code,
	input logic [SPAN_BITS-1:0]  span_start,
	input logic [SPAN_BITS-1:0]  span_end,
	input logic                  last_of_run
);

	`STS_ASSERT_NEXT(a_hold, token_valid && token_stall, token_valid, "token dropped while stalled")
	`STS_ASSERT_IMPLY(a_end_span, token_valid && token_kind == KIND_END, last_of_run && span_start == span_end, "bad end token")
	`STS_ASSERT_IMPLY(a_err_code, token_valid && token_kind != KIND_ERROR, error_code == ERR_NONE, "error code on normal token")
	`STS_ASSERT_NEXT(a_halt, token_valid && !token_stall && token_kind == KIND_ERROR, !token_valid, "token after error")

endmodule

bind sexpr_token_scanner_top sts_checker u_sts_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.token_valid (token_valid),
	.token_stall (token_stall),
	.token_kind  (token_kind),
	.error_code  (error_code),
	.span_start  (span_start),
	.span_end    (span_end),
	.last_of_run (last_of_run)
);

// ----- bench/tb.sv -----
// ----------------------------------------------------------------------------
// S-expression token scanner testbench
// Streams source bytes into the scanner under several idle/stall mixes and
// checks every token against an in-bench scanner model, in order.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import sts_pkg::*;

	localparam int CYCLE_LIMIT = 900_000;

	typedef struct {
		token_kind_t  kind;
		err_code_t    err;
		logic [15:0]  s;
		logic [15:0]  e;
		logic         last;
	} token_rec_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        data_valid = 1'b0;
	logic        data_stall;
	logic [7:0]  data_byte = 8'h00;
	logic        end_of_buffer = 1'b0;
	logic        token_valid;
	logic        token_stall = 1'b0;
	logic [2:0]  token_kind;
	logic [2:0]  error_code;
	logic [15:0] span_start;
	logic [15:0] span_end;
	logic        last_of_run;

	token_rec_t  expected_tokens[$];
	scan_mode_t  model_mode = MODE_IDLE;
	logic [15:0] model_pos = '0;
	logic [15:0] model_begin = '0;
	int          send_idle_pct = 0;
	int          stall_pct = 0;
	int          mismatches = 0;
	int          cycle_count = 0;

	sexpr_token_scanner_top u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.data_valid    (data_valid),
		.data_stall    (data_stall),
		.data_byte     (data_byte),
		.end_of_buffer (end_of_buffer),
		.token_valid   (token_valid),
		.token_stall   (token_stall),
		.token_kind    (token_kind),
		.error_code    (error_code),
		.span_start    (span_start),
		.span_end      (span_end),
		.last_of_run   (last_of_run)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		token_stall <= arst_n && ($urandom_range(99) < stall_pct);
	end

	function automatic logic is_alpha(input logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	function automatic logic is_num(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic logic is_blank(input logic [7:0] c);
		return c == 8'h09 || c == 8'h0A || c == 8'h0D || c == 8'h20;
	endfunction

	function automatic logic is_delim(input logic [7:0] c);
		return is_blank(c) || c == CH_LPAREN || c == CH_RPAREN;
	endfunction

	// scanner model: queues the tokens one accepted byte produces
	task automatic scan_byte(input logic [7:0] c, input logic eob);
		token_rec_t  toks[$];
		logic [15:0] here;
		logic [15:0] nxt;
		logic        fresh;
		here = model_pos;
		nxt = model_pos + 16'd1;
		fresh = 1'b0;
		case (model_mode)
			MODE_IDLE: fresh = 1'b1;
			MODE_STR: begin
				if (c == CH_QUOTE) begin
					toks.push_back('{KIND_STRING, ERR_NONE, model_begin, here, 1'b0});
					model_mode = MODE_IDLE;
				end else if (c < CH_PRINT_LO || c > CH_PRINT_HI) begin
					toks.push_back('{KIND_ERROR, ERR_STR_BYTE, model_begin, here, 1'b0});
					model_mode = MODE_HALT;
				end
			end
			MODE_IDENT, MODE_INT: begin
				if (is_delim(c)) begin
					toks.push_back('{(model_mode == MODE_IDENT) ? KIND_IDENT : KIND_INT,
						ERR_NONE, model_begin, here, 1'b0});
					model_mode = MODE_IDLE;
					fresh = 1'b1;
				end else if (model_mode == MODE_IDENT ? !is_alpha(c) : !is_num(c)) begin
					toks.push_back('{KIND_ERROR,
						(model_mode == MODE_IDENT) ? ERR_IDENT_BYTE : ERR_INT_BYTE,
						model_begin, here, 1'b0});
					model_mode = MODE_HALT;
				end
			end
			default: return;
		endcase
		if (fresh) begin
			if (c == CH_LPAREN) begin
				toks.push_back('{KIND_LPAREN, ERR_NONE, here, nxt, 1'b0});
			end else if (c == CH_RPAREN) begin
				toks.push_back('{KIND_RPAREN, ERR_NONE, here, nxt, 1'b0});
			end else if (c == CH_QUOTE) begin
				model_mode = MODE_STR;
				model_begin = nxt;
			end else if (is_alpha(c)) begin
				model_mode = MODE_IDENT;
				model_begin = here;
			end else if (is_num(c)) begin
				model_mode = MODE_INT;
				model_begin = here;
			end
		end
		model_pos = nxt;
		if (eob && model_mode != MODE_HALT) begin
			if (model_mode == MODE_STR) begin
				toks.push_back('{KIND_ERROR, ERR_UNTERM, model_begin, nxt, 1'b0});
				model_mode = MODE_HALT;
			end else begin
				if (model_mode == MODE_IDENT)
					toks.push_back('{KIND_IDENT, ERR_NONE, model_begin, nxt, 1'b0});
				else if (model_mode == MODE_INT)
					toks.push_back('{KIND_INT, ERR_NONE, model_begin, nxt, 1'b0});
				toks.push_back('{KIND_END, ERR_NONE, nxt, nxt, 1'b0});
				model_mode = MODE_IDLE;
				model_pos = '0;
				model_begin = '0;
			end
		end
		if (toks.size() > 0)
			toks[toks.size()-1].last = 1'b1;
		foreach (toks[i])
			expected_tokens.push_back(toks[i]);
	endtask

	task automatic send_byte(input logic [7:0] b, input logic eob);
		int gap;
		gap = 0;
		while (gap < 40 && $urandom_range(99) < send_idle_pct)
			gap++;
		if (gap > 0) begin
			data_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		scan_byte(b, eob);
		data_valid <= 1'b1;
		data_byte <= b;
		end_of_buffer <= eob;
		do @(posedge clk); while (data_stall);
	endtask

	task automatic send_text(input string s, input logic eob_at_end);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i], eob_at_end && (i == s.len() - 1));
	endtask

	// sender holds off until the scanner has delivered everything
	task automatic wait_drained();
		data_valid <= 1'b0;
		do @(posedge clk); while (expected_tokens.size() != 0);
	endtask

	task automatic set_idling(input int send_pct, input int recv_pct);
		send_idle_pct = send_pct;
		stall_pct = recv_pct;
	endtask

	function automatic logic [7:0] rand_letter();
		return ($urandom_range(1) ? 8'h41 : 8'h61) + 8'($urandom_range(25));
	endfunction

	function automatic logic [7:0] rand_delim();
		case ($urandom_range(5))
			0: return 8'h09;
			1: return 8'h0A;
			2: return 8'h0D;
			3: return 8'h20;
			4: return CH_LPAREN;
			default: return CH_RPAREN;
		endcase
	endfunction

	// bytes skipped while idle
	function automatic logic [7:0] rand_junk();
		logic [7:0] b;
		do b = 8'($urandom_range(255));
		while (is_alpha(b) || is_num(b) || b == CH_QUOTE || b == CH_LPAREN || b == CH_RPAREN);
		return b;
	endfunction

	task automatic send_random_buffer(output int n_sent);
		logic [7:0] text[$];
		logic [7:0] b;
		logic       open_word;
		int         len;
		open_word = 1'b0;
		repeat ($urandom_range(1, 8)) begin
			open_word = 1'b0;
			len = $urandom_range(1, 6);
			case ($urandom_range(9))
				0: text.push_back(CH_LPAREN);
				1: text.push_back(CH_RPAREN);
				2, 3: begin
					repeat (len) text.push_back(rand_letter());
					text.push_back(rand_delim());
					open_word = 1'b1;
				end
				4, 5: begin
					repeat (len) text.push_back(8'h30 + 8'($urandom_range(9)));
					text.push_back(rand_delim());
					open_word = 1'b1;
				end
				6: begin
					text.push_back(CH_QUOTE);
					repeat (len - 1) begin
						b = 8'($urandom_range(CH_PRINT_LO, CH_PRINT_HI));
						text.push_back(b == CH_QUOTE ? CH_PRINT_HI : b);
					end
					text.push_back(CH_QUOTE);
				end
				7: repeat (len) text.push_back(rand_delim() & 8'h2F);
				default: repeat (len) text.push_back(rand_junk());
			endcase
		end
		// let a word run into the end of the buffer so it gets flushed
		if (open_word && $urandom_range(1))
			void'(text.pop_back());
		foreach (text[i])
			send_byte(text[i], i == text.size() - 1);
		n_sent = text.size();
	endtask

	task automatic test_directed();
		send_text("(Az 09)", 1'b0);
		send_text("\t\n", 1'b0);
		send_byte(8'h0D, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(CH_QUOTE, 1'b0);
		send_byte(CH_PRINT_LO, 1'b0);
		send_byte(CH_PRINT_HI, 1'b0);
		send_byte(CH_QUOTE, 1'b0);
		send_text("\"\"", 1'b0);
		send_text("Zz)", 1'b1);
		send_text("7", 1'b1);
		send_text("(", 1'b1);
		send_text(" ", 1'b1);
	endtask

	task automatic test_random_traffic(input int n_bytes);
		int sent;
		int n;
		sent = 0;
		while (sent < n_bytes) begin
			send_random_buffer(n);
			sent += n;
		end
	endtask

	task automatic test_halt();
		err_code_t  err;
		logic [7:0] b;
		err = err_code_t'($urandom_range(ERR_STR_BYTE, ERR_UNTERM));
		case (err)
			ERR_STR_BYTE: begin
				send_text("\"a", 1'b0);
				b = $urandom_range(1) ? 8'($urandom_range(8'h00, 8'h1F))
					: 8'($urandom_range(8'h7F, 8'hFF));
				send_byte(b, 1'b0);
			end
			ERR_IDENT_BYTE: begin
				send_text("qr", 1'b0);
				do b = 8'($urandom_range(255)); while (is_alpha(b) || is_delim(b));
				send_byte(b, 1'b0);
			end
			ERR_INT_BYTE: begin
				send_text("42", 1'b0);
				do b = 8'($urandom_range(255)); while (is_num(b) || is_delim(b));
				send_byte(b, 1'b0);
			end
			default: send_text("\"a", 1'b1);
		endcase
		// halted: nothing below may produce a token
		send_text("(x 1)", 1'b1);
	endtask

	task automatic report(input string what, input int got, input int want);
		$display("mismatch at cycle %0d: %s got %0d expected %0d",
			cycle_count, what, got, want);
		mismatches++;
	endtask

	always @(posedge clk) begin
		token_rec_t w;
		cycle_count++;
		if (arst_n && token_valid && !token_stall) begin
			if (expected_tokens.size() == 0) begin
				report("unexpected token kind", token_kind, -1);
			end else begin
				w = expected_tokens.pop_front();
				if (token_kind !== w.kind)
					report("token_kind", token_kind, w.kind);
				if (error_code !== w.err)
					report("error_code", error_code, w.err);
				if (span_start !== w.s)
					report("span_start", span_start, w.s);
				if (span_end !== w.e)
					report("span_end", span_end, w.e);
				if (last_of_run !== w.last)
					report("last_of_run", last_of_run, w.last);
			end
		end
	end

	initial begin : watchdog
		wait (cycle_count >= CYCLE_LIMIT);
		$display("timeout with %0d tokens outstanding", expected_tokens.size());
		$display("*** FAILED ***");
		$finish;
	end

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		set_idling(10, 10);
		test_directed();
		wait_drained();

		set_idling(0, 0);
		test_random_traffic(70);
		wait_drained();
		set_idling(81, 0);
		test_random_traffic(70);
		set_idling(0, 81);
		test_random_traffic(70);
		wait_drained();
		set_idling(10, 10);
		test_random_traffic(70);

		test_halt();
		data_valid <= 1'b0;
		while (expected_tokens.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (mismatches == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
